// ----- hdl/hns_pkg.sv -----
// Shared types, constants and helpers of the heightfield normal shader.
`timescale 1ns / 1ps

package hns_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int MAX_ROWS  = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int DIM_W     = 11;
	localparam int GRID_W    = 10;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [1:0] K_STORE = 2'd0;
	localparam logic [1:0] K_EMIT  = 2'd1;
	localparam logic [1:0] K_DRAIN = 2'd2;

	localparam logic [1:0] R_GRID_WIDTH   = 2'd0;
	localparam logic [1:0] R_GRID_ROWS    = 2'd1;
	localparam logic [1:0] R_SLOPE_GAIN   = 2'd2;
	localparam logic [1:0] R_ALBEDO_COLOR = 2'd3;

	localparam logic signed [15:0] LIGHT_X = 16'sd11440;
	localparam logic signed [15:0] LIGHT_Y = 16'sd27783;
	localparam logic signed [15:0] LIGHT_Z = 16'sd13075;
	localparam logic [15:0] AMBIENT_Q15 = 16'd11469;
	localparam logic [15:0] DIFFUSE_Q15 = 16'd21299;
	localparam logic [16:0] ONE_Q15     = 17'd32768;
	localparam logic [7:0]  CH_MAX      = 8'hFF;

	typedef struct packed {
		logic [DIM_W-1:0]  grid_width;
		logic [DIM_W-1:0]  grid_rows;
		logic signed [23:0] slope_gain;
		logic [31:0]       albedo_color;
	} cfg_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [COL_W-1:0] x;
		logic [COL_W-1:0] xp;
		logic [COL_W-1:0] xm;
		logic [ROW_W-1:0] z;
		logic [15:0]      h;
		logic             left_c;
		logic             above_c;
		logic             sx2;
		logic             sz2;
		logic             last;
	} cmd_t;

	function automatic int clamp_dim(logic [DIM_W-1:0] v, int hi);
		int r;
		r = int'(v);
		if (r < 2) r = 2;
		else if (r > hi) r = hi;
		return r;
	endfunction

endpackage

// ----- hdl/hns_if.sv -----
// Stream channel interfaces for height words and shaded result words.
`timescale 1ns / 1ps

interface hns_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [15:0] height_sample;

	modport source (output valid, output func, output height_sample, input ready);
	modport sink (input valid, input func, input height_sample, output ready);
endinterface

interface hns_out_if;
	logic               valid;
	logic               ready;
	logic [9:0]         grid_x;
	logic [9:0]         grid_z;
	logic signed [15:0] normal_x;
	logic [14:0]        normal_y;
	logic signed [15:0] normal_z;
	logic [31:0]        shaded_color;
	logic               frame_last;

	modport source (output valid, output grid_x, output grid_z, output normal_x,
		output normal_y, output normal_z, output shaded_color, output frame_last,
		input ready);
	modport sink (input valid, input grid_x, input grid_z, input normal_x,
		input normal_y, input normal_z, input shaded_color, input frame_last,
		output ready);
endinterface

// ----- hdl/hns_front.sv -----
// Front end: accepts words, tracks raster position and classifies each word.
`timescale 1ns / 1ps

module hns_front import hns_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	hns_in_if.sink     in_ch,
	input  cfg_t       cfg,
	input  logic       q_full,
	output logic       push,
	output cmd_t       cmd
);

	logic [COL_W:0]   w;
	logic [ROW_W:0]   rows;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] drain_q;
	logic             draining_q;
	logic             acc;
	logic [COL_W-1:0] x;
	logic [COL_W:0]   x1;
	logic [COL_W-1:0] xp;
	logic [COL_W:0]   c1;
	logic [ROW_W:0]   r1;
	logic             last;

	assign w    = (COL_W+1)'(clamp_dim(cfg.grid_width, MAX_WIDTH));
	assign rows = (ROW_W+1)'(clamp_dim(cfg.grid_rows, MAX_ROWS));

	assign in_ch.ready = !q_full;
	assign acc  = in_ch.valid && in_ch.ready;
	assign push = acc && (in_ch.func == draining_q);

	assign x    = in_ch.func ? drain_q : col_q;
	assign x1   = (COL_W+1)'(x) + (COL_W+1)'(1);
	assign xp   = (x1 < w) ? x1[COL_W-1:0] : x;
	assign last = (x1 >= w);
	assign c1   = (COL_W+1)'(col_q) + (COL_W+1)'(1);
	assign r1   = (ROW_W+1)'(row_q) + (ROW_W+1)'(1);

	always_comb begin
		cmd.x      = x;
		cmd.xp     = xp;
		cmd.xm     = (x != '0) ? x - COL_W'(1) : x;
		cmd.h      = in_ch.height_sample;
		cmd.left_c = (x == '0);
		cmd.sx2    = (x != '0) && (xp != x);
		cmd.last   = last;
		if (in_ch.func) begin
			cmd.kind    = K_DRAIN;
			cmd.z       = ROW_W'(rows - (ROW_W+1)'(1));
			cmd.above_c = 1'b0;
			cmd.sz2     = 1'b0;
		end else begin
			cmd.kind    = (row_q != '0) ? K_EMIT : K_STORE;
			cmd.z       = row_q - ROW_W'(1);
			cmd.above_c = (row_q == ROW_W'(1));
			cmd.sz2     = (row_q != ROW_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			drain_q    <= '0;
			draining_q <= 1'b0;
		end else if (push) begin
			if (in_ch.func) begin
				if (last) begin
					drain_q    <= '0;
					draining_q <= 1'b0;
				end else begin
					drain_q <= x1[COL_W-1:0];
				end
			end else if (c1 >= w) begin
				col_q <= '0;
				if (r1 >= rows) begin
					row_q      <= '0;
					draining_q <= 1'b1;
					drain_q    <= '0;
				end else begin
					row_q <= r1[ROW_W-1:0];
				end
			end else begin
				col_q <= c1[COL_W-1:0];
			end
		end
	end

endmodule

// ----- hdl/hns_queue.sv -----
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module hns_queue import hns_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	input  logic pop,
	output logic full,
	output logic valid,
	output cmd_t head
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q;
	logic [QPTR_W-1:0] rp_q;
	logic [QPTR_W:0]   cnt_q;

	assign full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign valid = (cnt_q != '0);
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wp_q <= wp_q + QPTR_W'(1);
			if (pop && valid) rp_q <= rp_q + QPTR_W'(1);
			if ((push && !full) && !(pop && valid)) cnt_q <= cnt_q + (QPTR_W+1)'(1);
			else if (!(push && !full) && (pop && valid)) cnt_q <= cnt_q - (QPTR_W+1)'(1);
		end
	end

endmodule

// ----- hdl/hns_back.sv -----
// Back end: line stores, slope, normalization, shading and the output register.
`timescale 1ns / 1ps

module hns_back import hns_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       q_valid,
	input  cmd_t       q_head,
	output logic       q_pop,
	hns_out_if.source  out_ch
);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_RA    = 5'd1;
	localparam logic [4:0] S_RB    = 5'd2;
	localparam logic [4:0] S_RC    = 5'd3;
	localparam logic [4:0] S_DIFF  = 5'd4;
	localparam logic [4:0] S_MUL   = 5'd5;
	localparam logic [4:0] S_MAG   = 5'd6;
	localparam logic [4:0] S_SHIFT = 5'd7;
	localparam logic [4:0] S_SQ    = 5'd8;
	localparam logic [4:0] S_SUM   = 5'd9;
	localparam logic [4:0] S_SQRT  = 5'd10;
	localparam logic [4:0] S_DVI   = 5'd11;
	localparam logic [4:0] S_DIV   = 5'd12;
	localparam logic [4:0] S_SAT   = 5'd13;
	localparam logic [4:0] S_DOT   = 5'd14;
	localparam logic [4:0] S_DSUM  = 5'd15;
	localparam logic [4:0] S_KF    = 5'd16;
	localparam logic [4:0] S_COL   = 5'd17;
	localparam logic [4:0] S_OUT   = 5'd18;

	localparam int MAGW = 41;
	localparam logic [MAGW-1:0] MY0 = MAGW'(131072);
	localparam logic [MAGW-1:0] LIM = MAGW'(1073741824);

	logic [4:0]  state_q;
	cmd_t        cur_q;

	logic [15:0] mid_mem [MAX_WIDTH];
	logic [15:0] up_mem  [MAX_WIDTH];
	logic [15:0] mid_rd;
	logic [15:0] up_rd;
	logic [COL_W-1:0] mid_ra, up_ra, mid_wa;
	logic [15:0] mid_wd;
	logic        mid_we, up_we;

	logic [15:0] c_q, above_q, right_q, leftu_q;
	logic signed [16:0] dhx_q, dhz_q;
	logic signed [40:0] px_q, pz_q;
	logic [MAGW-1:0] mx_q, mz_q;
	logic        nx_neg_q, nz_neg_q;
	logic [29:0] sm_q [3];
	logic [59:0] sqp_q [3];
	logic [61:0] sv_q, sres_q, sbit_q;
	logic [4:0]  scnt_q;
	logic [30:0] rdiv_q;
	logic [46:0] rem_q [3];
	logic [15:0] dq_q [3];
	logic [3:0]  dcnt_q;
	logic signed [15:0] nrx_q, nrz_q;
	logic [14:0] nry_q;
	logic signed [31:0] lp_q [3];
	logic [30:0] d_q;
	logic [15:0] k_q;
	logic [31:0] color_q;

	logic        ovalid_q;
	logic [9:0]  ox_q, oz_q;
	logic signed [15:0] onx_q, onz_q;
	logic [14:0] ony_q;
	logic [31:0] ocol_q;
	logic        olast_q;
	logic        out_load;

	logic [15:0] leftsel, abovesel;
	logic signed [41:0] tx, tz, vx, vz;
	logic [MAGW-1:0] mmax;
	logic [3:0]  sh;
	logic [61:0] strial;
	logic [46:0] dtrial;
	logic [2:0]  dge;
	logic signed [31:0] dsum;
	logic [45:0] dk;
	logic [16:0] kk;
	logic [23:0] ch [3];
	logic [31:0] color_n;

	function automatic logic [15:0] sat_comp(logic [15:0] q, logic neg);
		logic [15:0] r;
		if (neg) r = (q > 16'd32768) ? 16'h8000 : 16'(-{1'b0, q});
		else r = (q > 16'd32767) ? 16'h7FFF : q;
		return r;
	endfunction

	assign q_pop    = (state_q == S_IDLE) && q_valid;
	assign out_load = (state_q == S_OUT) && (!ovalid_q || out_ch.ready);

	always_comb begin
		mid_ra = cur_q.x;
		up_ra  = cur_q.x;
		unique case (state_q)
			S_RB: begin
				mid_ra = cur_q.xp;
				up_ra  = cur_q.xm;
			end
			S_RC: mid_ra = cur_q.xm;
			default: ;
		endcase
	end

	assign mid_we = (q_pop && q_head.kind == K_STORE) ||
		(state_q == S_DIFF && cur_q.kind == K_EMIT);
	assign mid_wa = (state_q == S_IDLE) ? q_head.x : cur_q.x;
	assign mid_wd = (state_q == S_IDLE) ? q_head.h : cur_q.h;
	assign up_we  = (state_q == S_DIFF) && (cur_q.kind == K_EMIT);

	always_ff @(posedge clk) begin
		if (mid_we) mid_mem[mid_wa] <= mid_wd;
		mid_rd <= mid_mem[mid_ra];
	end

	always_ff @(posedge clk) begin
		if (up_we) up_mem[cur_q.x] <= c_q;
		up_rd <= up_mem[up_ra];
	end

	always_comb begin
		if (cur_q.kind == K_DRAIN) leftsel = mid_rd;
		else leftsel = cur_q.left_c ? c_q : leftu_q;
		abovesel = cur_q.above_c ? c_q : above_q;
		tx = -{px_q[40], px_q};
		tz = -{pz_q[40], pz_q};
		vx = cur_q.sx2 ? tx : (tx <<< 1);
		vz = cur_q.sz2 ? tz : (tz <<< 1);
		mmax = (mx_q > mz_q) ? mx_q : mz_q;
		if (MY0 > mmax) mmax = MY0;
		sh = '0;
		for (int i = 0; i <= MAGW - 30; i++) begin
			if ((mmax >> i) >= LIM) sh = 4'(i + 1);
		end
		strial = sres_q + sbit_q;
		dtrial = 47'(rdiv_q) << dcnt_q;
		for (int i = 0; i < 3; i++) dge[i] = (rem_q[i] >= dtrial);
		dsum = lp_q[0] + lp_q[1] + lp_q[2];
		dk = 46'(d_q) * 46'(DIFFUSE_Q15);
		kk = 17'(AMBIENT_Q15) + 17'(dk >> 30);
		color_n = {cfg.albedo_color[31:24], 24'd0};
		for (int c = 0; c < 3; c++) begin
			ch[c] = 24'(cfg.albedo_color[8*c +: 8]) * 24'(k_q);
			color_n[8*c +: 8] = ((ch[c] >> 15) > 24'(CH_MAX)) ? CH_MAX : ch[c][22:15];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:  if (q_valid && q_head.kind != K_STORE) state_q <= S_RA;
				S_RA:    state_q <= S_RB;
				S_RB:    state_q <= S_RC;
				S_RC:    state_q <= S_DIFF;
				S_DIFF:  state_q <= S_MUL;
				S_MUL:   state_q <= S_MAG;
				S_MAG:   state_q <= S_SHIFT;
				S_SHIFT: state_q <= S_SQ;
				S_SQ:    state_q <= S_SUM;
				S_SUM:   state_q <= S_SQRT;
				S_SQRT:  if (scnt_q == '0) state_q <= S_DVI;
				S_DVI:   state_q <= S_DIV;
				S_DIV:   if (dcnt_q == '0) state_q <= S_SAT;
				S_SAT:   state_q <= S_DOT;
				S_DOT:   state_q <= S_DSUM;
				S_DSUM:  state_q <= S_KF;
				S_KF:    state_q <= S_COL;
				S_COL:   state_q <= S_OUT;
				S_OUT:   if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (q_valid) cur_q <= q_head;
			S_RB: begin
				c_q     <= mid_rd;
				above_q <= up_rd;
			end
			S_RC: begin
				right_q <= mid_rd;
				leftu_q <= up_rd;
			end
			S_DIFF: begin
				dhx_q <= $signed({1'b0, right_q}) - $signed({1'b0, leftsel});
				if (cur_q.kind == K_DRAIN)
					dhz_q <= $signed({1'b0, c_q}) - $signed({1'b0, above_q});
				else
					dhz_q <= $signed({1'b0, cur_q.h}) - $signed({1'b0, abovesel});
			end
			S_MUL: begin
				px_q <= dhx_q * cfg.slope_gain;
				pz_q <= dhz_q * cfg.slope_gain;
			end
			S_MAG: begin
				nx_neg_q <= vx[41];
				nz_neg_q <= vz[41];
				mx_q <= vx[41] ? MAGW'(-vx) : vx[MAGW-1:0];
				mz_q <= vz[41] ? MAGW'(-vz) : vz[MAGW-1:0];
			end
			S_SHIFT: begin
				sm_q[0] <= 30'(mx_q >> sh);
				sm_q[1] <= 30'(MY0 >> sh);
				sm_q[2] <= 30'(mz_q >> sh);
			end
			S_SQ: for (int i = 0; i < 3; i++) sqp_q[i] <= sm_q[i] * sm_q[i];
			S_SUM: begin
				sv_q   <= 62'(sqp_q[0]) + 62'(sqp_q[1]) + 62'(sqp_q[2]);
				sres_q <= '0;
				sbit_q <= 62'(1) << 60;
				scnt_q <= 5'd30;
			end
			S_SQRT: begin
				if (sv_q >= strial) begin
					sv_q   <= sv_q - strial;
					sres_q <= (sres_q >> 1) + sbit_q;
				end else begin
					sres_q <= sres_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
				scnt_q <= scnt_q - 5'd1;
			end
			S_DVI: begin
				rdiv_q <= sres_q[30:0];
				for (int i = 0; i < 3; i++) begin
					rem_q[i] <= {2'b00, sm_q[i], 15'd0};
					dq_q[i]  <= '0;
				end
				dcnt_q <= 4'd15;
			end
			S_DIV: begin
				for (int i = 0; i < 3; i++) begin
					if (dge[i]) rem_q[i] <= rem_q[i] - dtrial;
					dq_q[i] <= {dq_q[i][14:0], dge[i]};
				end
				dcnt_q <= dcnt_q - 4'd1;
			end
			S_SAT: begin
				nrx_q <= $signed(sat_comp(dq_q[0], nx_neg_q));
				nry_q <= (dq_q[1] > 16'd32767) ? 15'h7FFF : dq_q[1][14:0];
				nrz_q <= $signed(sat_comp(dq_q[2], nz_neg_q));
			end
			S_DOT: begin
				lp_q[0] <= nrx_q * LIGHT_X;
				lp_q[1] <= $signed({1'b0, nry_q}) * LIGHT_Y;
				lp_q[2] <= nrz_q * LIGHT_Z;
			end
			S_DSUM: d_q <= dsum[31] ? '0 : dsum[30:0];
			S_KF:   k_q <= (kk > ONE_Q15) ? ONE_Q15[15:0] : kk[15:0];
			S_COL:  color_q <= color_n;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovalid_q <= 1'b0;
		else if (out_load) ovalid_q <= 1'b1;
		else if (out_ch.ready) ovalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			ox_q    <= GRID_W'(cur_q.x);
			oz_q    <= GRID_W'(cur_q.z);
			onx_q   <= nrx_q;
			ony_q   <= nry_q;
			onz_q   <= nrz_q;
			ocol_q  <= color_q;
			olast_q <= (cur_q.kind == K_DRAIN) && cur_q.last;
		end
	end

	assign out_ch.valid        = ovalid_q;
	assign out_ch.grid_x       = ox_q;
	assign out_ch.grid_z       = oz_q;
	assign out_ch.normal_x     = onx_q;
	assign out_ch.normal_y     = ony_q;
	assign out_ch.normal_z     = onz_q;
	assign out_ch.shaded_color = ocol_q;
	assign out_ch.frame_last   = olast_q;

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && dcnt_q == '0) |=>
		(dq_q[0] <= 16'd32768 && dq_q[1] <= 16'd32768 && dq_q[2] <= 16'd32768))
		else $error("normal quotient above one");

	a_sqrt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQRT && scnt_q == '0) |=> (sres_q < (62'd1 << 31)))
		else $error("root wider than 31 bits");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && ovalid_q && !out_ch.ready) |=> (state_q == S_OUT))
		else $error("result dropped while receiver stalls");

	a_store_pair: assert property (@(posedge clk) disable iff (!arst_n)
		up_we |-> (mid_we && state_q == S_DIFF))
		else $error("line stores updated out of step");

endmodule

// ----- hdl/heightfield_normal_shader_top.sv -----
// Top level of the heightfield normal shader: configuration and block wiring.
//
// sample_ch takes one word per height sample in raster order (func 0) or one
// drain tick (func 1); a word is taken when valid and ready are both high.
// result_ch delivers one word per grid point: position, Q1.15 unit normal,
// Lambert-shaded color and frame_last on the final point of the map.
// The point of a row is emitted when the sample below it arrives; after the
// last sample of a frame, grid_width drain ticks flush the bottom row.
// Samples during a drain and ticks outside one are taken and dropped.
// A first-row sample is only stored in the back end; an emitting word passes the
// 31-step square root and the 16-step divider that share one sequencer before
// the next word is taken. A 4-word queue lets the front keep taking words, and
// the output register holds a finished word while the receiver stalls. Reset
// clears the raster counters, the queue and the output; the line stores hold
// garbage until the first row is written. Registers are written through wr_en /
// wr_index / wr_data only while idle: a user rule the block does not enforce.
`timescale 1ns / 1ps

module heightfield_normal_shader_top import hns_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	hns_in_if.sink      sample_ch,
	hns_out_if.source   result_ch,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [31:0] wr_data
);

	cfg_t cfg_q;
	logic push, full, q_valid, q_pop;
	cmd_t cmd, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_width   <= DIM_W'(2);
			cfg_q.grid_rows    <= DIM_W'(2);
			cfg_q.slope_gain   <= 24'sd65536;
			cfg_q.albedo_color <= 32'hFFFF_FFFF;
		end else if (wr_en) begin
			unique case (wr_index)
				R_GRID_WIDTH:   cfg_q.grid_width   <= wr_data[DIM_W-1:0];
				R_GRID_ROWS:    cfg_q.grid_rows    <= wr_data[DIM_W-1:0];
				R_SLOPE_GAIN:   cfg_q.slope_gain   <= $signed(wr_data[23:0]);
				R_ALBEDO_COLOR: cfg_q.albedo_color <= wr_data;
				default: ;
			endcase
		end
	end

	hns_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (sample_ch),
		.cfg    (cfg_q),
		.q_full (full),
		.push   (push),
		.cmd    (cmd)
	);

	hns_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd),
		.pop    (q_pop),
		.full   (full),
		.valid  (q_valid),
		.head   (head)
	);

	hns_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_head  (head),
		.q_pop   (q_pop),
		.out_ch  (result_ch)
	);

endmodule

// ----- verif/heightfield_normal_shader_top_tb.sv -----
// Testbench of heightfield_normal_shader_top: random heightmap frames checked against a scoreboard.
`timescale 1ns / 1ps

module heightfield_normal_shader_top_tb import hns_pkg::*; ();

	typedef struct {
		bit [9:0]  grid_x;
		bit [9:0]  grid_z;
		bit [15:0] normal_x;
		bit [14:0] normal_y;
		bit [15:0] normal_z;
		bit [31:0] shaded_color;
		bit        frame_last;
	} point_t;

	class shade_scoreboard;
		bit [15:0] row_above [MAX_WIDTH];
		bit [15:0] row_mid [MAX_WIDTH];
		int unsigned col;
		int unsigned row;
		int unsigned drain_col;
		bit draining;
		bit [10:0] width_reg = 11'd2;
		bit [10:0] rows_reg = 11'd2;
		bit [23:0] gain_reg = 24'd65536;
		bit [31:0] albedo_reg = 32'hFFFF_FFFF;
		point_t points_due [$];
		int errors;

		function void configure(bit [1:0] idx, bit [31:0] val);
			case (idx)
			R_GRID_WIDTH: width_reg = val[10:0];
			R_GRID_ROWS: rows_reg = val[10:0];
			R_SLOPE_GAIN: gain_reg = val[23:0];
			default: albedo_reg = val;
			endcase
		endfunction

		function int unsigned clampd(bit [10:0] v, int unsigned hi);
			if (v < 2) return 2;
			return v > hi ? hi : v;
		endfunction

		function longint unsigned root(longint unsigned v);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function longint unit(longint unsigned m, bit neg, longint unsigned r);
			longint unsigned q;
			q = (m << 15) / r;
			if (neg) return q > 32768 ? -32768 : -longint'(q);
			return q > 32767 ? 32767 : longint'(q);
		endfunction

		function void shade(int unsigned x, int unsigned z, longint dhx, int unsigned sx,
				longint dhz, int unsigned sz, bit last);
			longint g, vx, vz, nx, ny, nz, d;
			longint unsigned mx, my, mz, mmax, r, k, ch;
			point_t p;
			g = longint'($signed(gain_reg));
			vx = -dhx * g;
			vz = -dhz * g;
			if (sx == 1) vx *= 2;
			if (sz == 1) vz *= 2;
			mx = vx < 0 ? -vx : vx;
			mz = vz < 0 ? -vz : vz;
			my = 64'd1 << 17;
			mmax = mx > mz ? mx : mz;
			if (my > mmax) mmax = my;
			while (mmax >= (64'd1 << 30)) begin
				mmax >>= 1;
				mx >>= 1;
				my >>= 1;
				mz >>= 1;
			end
			r = root(mx * mx + my * my + mz * mz);
			if (r == 0) r = 1;
			nx = unit(mx, vx < 0, r);
			ny = unit(my, 1'b0, r);
			nz = unit(mz, vz < 0, r);
			d = nx * longint'(LIGHT_X) + ny * longint'(LIGHT_Y) + nz * longint'(LIGHT_Z);
			if (d < 0) d = 0;
			k = longint'(AMBIENT_Q15) + ((longint'(d) * longint'(DIFFUSE_Q15)) >> 30);
			if (k > ONE_Q15) k = ONE_Q15;
			p.shaded_color = {albedo_reg[31:24], 24'd0};
			for (int c = 0; c < 3; c++) begin
				ch = (longint'(albedo_reg[8*c +: 8]) * k) >> 15;
				if (ch > CH_MAX) ch = CH_MAX;
				p.shaded_color[8*c +: 8] = ch[7:0];
			end
			p.grid_x = x[9:0];
			p.grid_z = z[9:0];
			p.normal_x = nx[15:0];
			p.normal_y = ny[14:0];
			p.normal_z = nz[15:0];
			p.frame_last = last;
			points_due = {points_due, p};
		endfunction

		function void note_word(bit func, bit [15:0] h);
			int unsigned w, rows, x, xm, xp, z;
			longint c, left, right, above;
			w = clampd(width_reg, MAX_WIDTH);
			rows = clampd(rows_reg, MAX_ROWS);
			if (func) begin
				x = drain_col;
				if (!draining || x >= MAX_WIDTH) return;
				xm = x > 0 ? x - 1 : x;
				xp = x + 1 < w ? x + 1 : x;
				shade(x, rows - 1, longint'(row_mid[xp]) - longint'(row_mid[xm]), xp - xm,
					longint'(row_mid[x]) - longint'(row_above[x]), 1, x + 1 >= w);
				if (x + 1 >= w) begin
					drain_col = 0;
					draining = 0;
				end else begin
					drain_col = x + 1;
				end
				return;
			end
			if (draining) return;
			x = col >= MAX_WIDTH ? MAX_WIDTH - 1 : col;
			if (row >= 1) begin
				z = row - 1;
				xp = x + 1 < w ? x + 1 : x;
				c = row_mid[x];
				left = x > 0 ? longint'(row_above[x - 1]) : c;
				right = xp != x ? longint'(row_mid[xp]) : c;
				above = z > 0 ? longint'(row_above[x]) : c;
				shade(x, z, right - left, xp - (x > 0 ? x - 1 : x), longint'(h) - above,
					z > 0 ? 2 : 1, 1'b0);
				row_above[x] = row_mid[x];
			end
			row_mid[x] = h;
			if (col + 1 >= w) begin
				col = 0;
				if (row + 1 >= rows) begin
					row = 0;
					draining = 1;
					drain_col = 0;
				end else begin
					row++;
				end
			end else begin
				col++;
			end
		endfunction

		function void cmp(string name, longint unsigned exp_v, longint unsigned act_v);
			if (exp_v != act_v) begin
				$error("%s: expected %0h, got %0h", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check(point_t got);
			point_t e;
			if (points_due.size() == 0) begin
				$error("unexpected result word at x=%0d z=%0d", got.grid_x, got.grid_z);
				errors++;
				return;
			end
			e = points_due.pop_front();
			cmp("grid_x", e.grid_x, got.grid_x);
			cmp("grid_z", e.grid_z, got.grid_z);
			cmp("normal_x", e.normal_x, got.normal_x);
			cmp("normal_y", e.normal_y, got.normal_y);
			cmp("normal_z", e.normal_z, got.normal_z);
			cmp("shaded_color", e.shaded_color, got.shaded_color);
			cmp("frame_last", e.frame_last, got.frame_last);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [1:0] wr_index = R_GRID_WIDTH;
	logic [31:0] wr_data = 32'd0;
	hns_in_if sample_ch();
	hns_out_if result_ch();

	shade_scoreboard sb = new();
	bit hold_req;
	bit rx_busy = 1;
	bit tx_busy = 1;
	int unsigned samples_sent;

	heightfield_normal_shader_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_ch(sample_ch),
		.result_ch(result_ch),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always #4 clk = ~clk;

	initial begin
		sample_ch.valid = 1'b0;
		sample_ch.func = 1'b0;
		sample_ch.height_sample = 16'd0;
		result_ch.ready = 1'b0;
	end

	initial begin
		#50_000_000;
		$display("heightfield_normal_shader_top test failed");
		$finish;
	end

	task automatic send_word(bit func, bit [15:0] h);
		int unsigned gap;
		bit took;
		if ($urandom_range(0, 39) == 0) tx_busy = ~tx_busy;
		gap = tx_busy ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			sample_ch.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1;
		sample_ch.func <= func;
		sample_ch.height_sample <= h;
		do begin
			@(negedge clk);
			took = sample_ch.ready;
			@(posedge clk);
		end while (!took);
		sb.note_word(func, h);
	endtask

	task automatic wait_idle();
		sample_ch.valid <= 0;
		while (sb.points_due.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(bit [1:0] idx, bit [31:0] val);
		wr_en <= 1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		sb.configure(idx, val);
	endtask

	function automatic bit [15:0] pick_height(bit [15:0] prev);
		case ($urandom_range(0, 5))
		0: return 16'h0000;
		1: return 16'hFFFF;
		2: return prev + 16'($urandom_range(0, 15)) - 16'd8;
		default: return 16'($urandom);
		endcase
	endfunction

	function automatic bit [31:0] pick_gain();
		case ($urandom_range(0, 5))
		0: return 32'h0080_0000;
		1: return 32'h007F_FFFF;
		2: return 32'd0;
		3: return 32'($urandom_range(0, 511));
		default: return $urandom;
		endcase
	endfunction

	task automatic run_frame(bit [10:0] w_reg, bit [10:0] rows_reg, bit [31:0] gain,
			bit [31:0] albedo, bit noise);
		int unsigned w, rows;
		bit [15:0] h;
		wait_idle();
		write_reg(R_GRID_WIDTH, 32'(w_reg));
		write_reg(R_GRID_ROWS, 32'(rows_reg));
		write_reg(R_SLOPE_GAIN, gain);
		write_reg(R_ALBEDO_COLOR, albedo);
		wr_en <= 0;
		w = sb.clampd(w_reg, MAX_WIDTH);
		rows = sb.clampd(rows_reg, MAX_ROWS);
		h = 16'($urandom);
		for (int i = 0; i < w * rows; i++) begin
			if (noise && $urandom_range(0, 19) == 0) send_word(1'b1, 16'($urandom));
			h = pick_height(h);
			send_word(1'b0, h);
		end
		samples_sent += w * rows;
		for (int i = 0; i < w; i++) begin
			if (noise && $urandom_range(0, 9) == 0) send_word(1'b0, 16'($urandom));
			send_word(1'b1, 16'($urandom));
		end
		if (noise && $urandom_range(0, 3) == 0) send_word(1'b1, 16'($urandom));
	endtask

	always begin
		int unsigned stall;
		bit got;
		point_t p;
		if (!arst_n) begin
			@(posedge clk);
		end else begin
			if (hold_req) begin
				result_ch.ready <= 0;
				repeat (400) @(posedge clk);
				hold_req = 0;
			end
			if ($urandom_range(0, 39) == 0) rx_busy = ~rx_busy;
			stall = rx_busy ? $urandom_range(0, 11) : 0;
			if (stall > 0) begin
				result_ch.ready <= 0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1;
			do begin
				@(negedge clk);
				got = result_ch.valid;
				p.grid_x = result_ch.grid_x;
				p.grid_z = result_ch.grid_z;
				p.normal_x = result_ch.normal_x;
				p.normal_y = result_ch.normal_y;
				p.normal_z = result_ch.normal_z;
				p.shaded_color = result_ch.shaded_color;
				p.frame_last = result_ch.frame_last;
				@(posedge clk);
			end while (!got);
			sb.check(p);
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_word(1'b1, 16'hFFFF);
		send_word(1'b0, 16'h0000);
		send_word(1'b0, 16'hFFFF);
		send_word(1'b0, 16'hFFFF);
		send_word(1'b0, 16'h0000);
		send_word(1'b0, 16'h1234);
		send_word(1'b1, 16'h0000);
		send_word(1'b1, 16'h0000);
		send_word(1'b1, 16'h0000);
		run_frame(11'd3, 11'd3, 32'h007F_FFFF, 32'h80FF_40C0, 1'b0);
		run_frame(11'd3, 11'd3, 32'h0080_0000, 32'h0000_0000, 1'b0);
		run_frame(11'd1, 11'd0, 32'd0, 32'hFFFF_FFFF, 1'b0);
		hold_req = 1;
		run_frame(11'd6, 11'd4, 32'h0001_0000, $urandom, 1'b1);
		run_frame(11'd40, 11'd3, pick_gain(), $urandom, 1'b0);
		run_frame(11'd2, 11'd30, pick_gain(), $urandom, 1'b0);
		samples_sent = 0;
		while (samples_sent < 1000) begin
			if ($urandom_range(0, 9) == 0) hold_req = 1;
			run_frame(11'($urandom_range(0, 9)), 11'($urandom_range(0, 7)), pick_gain(),
				$urandom, 1'b1);
		end
		wait_idle();
		if (sb.errors == 0) begin
			$display("heightfield_normal_shader_top test passed");
		end else begin
			$display("heightfield_normal_shader_top test failed");
		end
		$finish;
	end

endmodule
